>>> src/ismet_pkg.sv
// Package for the Metropolis spin-update block: lattice geometry, field widths,
// register indexes and the stride helper. No dependencies.
package ismet_pkg;

  localparam int SIDE = 64;
  localparam int DIMS = 2;

  localparam longint unsigned SITES = longint'(SIDE) ** DIMS;
  localparam int LAT_DEPTH = int'(SITES);
  localparam int ADDR_W = (LAT_DEPTH > 1) ? $clog2(LAT_DEPTH) : 1;
  localparam int SIDE_W = $clog2(SIDE);
  localparam int DIM_W = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int UPS_W = $clog2(2 * DIMS + 1);

  // Exact quotient by SIDE through a reciprocal: 2^K exceeds any address times SIDE.
  localparam int RECIP_K = ADDR_W + SIDE_W + 1;
  localparam int PROD_W = ADDR_W + RECIP_K + 1;
  localparam logic [PROD_W-1:0] RECIP = PROD_W'((64'(1) << RECIP_K) / SIDE + 1);

  // Field widths.
  localparam int SITE_W = 12;
  localparam int UNI_W = 32;
  localparam int THR_W = 32;
  localparam int DE_W = 6;
  localparam int EN_W = 15;
  localparam int MAG_W = 14;
  localparam int CFG_IDX_W = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THR4 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR8 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR12 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR16 = 2'd3;

  localparam logic [THR_W-1:0] THR_RESET = '1;
  localparam logic [EN_W-1:0] E_RESET = EN_W'(64'(0) - 64'(DIMS) * SITES);
  localparam logic [MAG_W-1:0] M_RESET = MAG_W'(64'(0) - SITES);

  // Address distance between neighbours along dimension d.
  function automatic logic [ADDR_W:0] stride_of(input logic [DIM_W-1:0] d);
    logic [ADDR_W:0] s;
    s = (ADDR_W + 1)'(1);
    for (int i = 0; i < DIMS; i++) begin
      if (i < int'(d)) begin
        s = (ADDR_W + 1)'(s * (ADDR_W + 1)'(SIDE));
      end
    end
    return s;
  endfunction

endpackage

>>> src/ismet_in_if.sv
// Input item channel of the spin-update block.
// Depends on ismet_pkg for the field widths.
interface ismet_in_if import ismet_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SITE_W-1:0] site;
  logic [UNI_W-1:0]  uniform;
  logic              spin_value;

  modport source (output valid, mode, site, uniform, spin_value, input ready);
  modport sink (input valid, mode, site, uniform, spin_value, output ready);
endinterface

>>> src/ismet_out_if.sv
// Result item channel of the spin-update block.
// Depends on ismet_pkg for the field widths.
interface ismet_out_if import ismet_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    flipped;
  logic                    spin_now;
  logic signed [DE_W-1:0]  energy_delta;
  logic signed [EN_W-1:0]  energy_now;
  logic signed [MAG_W-1:0] magnetization;

  modport source (output valid, flipped, spin_now, energy_delta, energy_now, magnetization,
                  input ready);
  modport sink (input valid, flipped, spin_now, energy_delta, energy_now, magnetization,
                output ready);
endinterface

>>> src/ismet_cfg_if.sv
// Configuration write channel of the spin-update block.
// Depends on ismet_pkg for the index and data widths.
interface ismet_cfg_if import ismet_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [THR_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/ising_metropolis_spin_update_top.sv
// Metropolis single-spin-flip engine on a periodic lattice of SIDE^DIMS one-bit spins
// held in one lattice RAM. After reset the block clears the RAM one spin per cycle
// before it accepts its first item; configuration writes are taken at any time. For
// an item at a valid site, for each dimension the shared reciprocal multiplier
// extracts one coordinate (states QUOT and DIGIT), and the single RAM read port
// fetches the two wrapped neighbours (states UP and DOWN); then the block evaluates,
// presents the result and returns to idle, the only state in which it accepts the
// next item. A site beyond the lattice goes straight to presenting the result.
// Results wait in an output register until taken.
// Depends on ismet_pkg, the three channel interfaces and ismet_ram.
module ising_metropolis_spin_update_top import ismet_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ismet_in_if.sink     item_in,
  ismet_out_if.source  item_out,
  ismet_cfg_if.sink    cfg
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_QUOT  = 3'd2;
  localparam logic [2:0] ST_DIGIT = 3'd3;
  localparam logic [2:0] ST_UP    = 3'd4;
  localparam logic [2:0] ST_DOWN  = 3'd5;
  localparam logic [2:0] ST_EVAL  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_SELF = 2'd1;
  localparam logic [1:0] RD_NBR  = 2'd2;

  logic [2:0]        state;
  logic [1:0]        rd_kind;
  logic [1:0]        rd_kind_next;
  logic [ADDR_W-1:0] clr_addr;

  logic [THR_W-1:0]  thr4;
  logic [THR_W-1:0]  thr8;
  logic [THR_W-1:0]  thr12;
  logic [THR_W-1:0]  thr16;

  logic [EN_W-1:0]   energy;
  logic [MAG_W-1:0]  magnet;

  logic              mode;
  logic [ADDR_W-1:0] site;
  logic [UNI_W-1:0]  uniform;
  logic              spin_value;
  logic              spin;
  logic [UPS_W-1:0]  ups;
  logic [ADDR_W-1:0] cur;
  logic [PROD_W-1:0] prod;
  logic [SIDE_W-1:0] coord;
  logic [DIM_W-1:0]  dim;

  logic              res_flipped;
  logic              res_spin_now;
  logic [DE_W-1:0]   res_delta;
  logic [EN_W-1:0]   res_energy;
  logic [MAG_W-1:0]  res_magnet;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic              ram_rdata;

  logic              in_accept;
  logic              site_ok;
  logic [ADDR_W:0]   stride;
  logic [ADDR_W:0]   wrap;
  logic [ADDR_W:0]   site_ext;
  logic [ADDR_W:0]   up_addr;
  logic [ADDR_W:0]   dn_addr;
  logic [ADDR_W-1:0] quot;
  logic [ADDR_W:0]   digit_diff;
  logic [UPS_W-1:0]  ups_full;
  logic [6:0]        two_n;
  logic [6:0]        de_wide;
  logic [DE_W-1:0]   de;
  logic [1:0]        thr_idx;
  logic [THR_W-1:0]  thr_sel;
  logic              flip;
  logic [EN_W-1:0]   energy_next;
  logic [MAG_W-1:0]  magnet_next;

  assign in_accept = item_in.valid && item_in.ready;
  assign item_in.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign site_ok = 64'(item_in.site) < SITES;

  // Neighbour addresses along the current dimension, wrapped at the lattice edge.
  assign stride = stride_of(dim);
  assign wrap = (ADDR_W + 1)'(stride * (ADDR_W + 1)'(SIDE - 1));
  assign site_ext = {1'b0, site};
  assign up_addr = (coord == SIDE_W'(SIDE - 1)) ? site_ext - wrap : site_ext + stride;
  assign dn_addr = (coord == '0) ? site_ext + wrap : site_ext - stride;

  assign quot = ADDR_W'(prod >> RECIP_K);
  assign digit_diff = (ADDR_W + 1)'(cur) - (ADDR_W + 1)'((ADDR_W + 1)'(quot) *
                      (ADDR_W + 1)'(SIDE));

  // The last neighbour bit arrives during the evaluation cycle.
  assign ups_full = (rd_kind == RD_NBR) ? ups + UPS_W'(ram_rdata) : ups;
  assign two_n = (7'(ups_full) << 2) - 7'(4 * DIMS);
  assign de_wide = spin ? two_n : 7'(0) - two_n;
  assign de = de_wide[DE_W-1:0];
  assign thr_idx = 2'(de[4:2] - 3'd1);

  always_comb begin
    case (thr_idx)
      CFG_THR4:  thr_sel = thr4;
      CFG_THR8:  thr_sel = thr8;
      CFG_THR12: thr_sel = thr12;
      default:   thr_sel = thr16;
    endcase
  end

  always_comb begin
    if (mode) begin
      flip = (spin_value != spin);
    end else if (de[DE_W-1] || de == '0) begin
      flip = 1'b1;
    end else begin
      flip = uniform < thr_sel;
    end
  end

  assign energy_next = flip ? energy + {{(EN_W - DE_W){de[DE_W-1]}}, de} : energy;
  assign magnet_next = !flip ? magnet :
                       (spin ? magnet - MAG_W'(2) : magnet + MAG_W'(2));

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = site;
    ram_wdata = ~spin;
    ram_re = 1'b0;
    ram_raddr = ADDR_W'(item_in.site);
    rd_kind_next = RD_NONE;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 1'b0;
      end
      ST_IDLE: begin
        if (in_accept && site_ok) begin
          ram_re = 1'b1;
          rd_kind_next = RD_SELF;
        end
      end
      ST_UP: begin
        ram_re = 1'b1;
        ram_raddr = up_addr[ADDR_W-1:0];
        rd_kind_next = RD_NBR;
      end
      ST_DOWN: begin
        ram_re = 1'b1;
        ram_raddr = dn_addr[ADDR_W-1:0];
        rd_kind_next = RD_NBR;
      end
      ST_EVAL: begin
        ram_we = flip;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr4 <= THR_RESET;
      thr8 <= THR_RESET;
      thr12 <= THR_RESET;
      thr16 <= THR_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_THR4:  thr4 <= cfg.data;
        CFG_THR8:  thr8 <= cfg.data;
        CFG_THR12: thr12 <= cfg.data;
        default:   thr16 <= cfg.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      rd_kind <= RD_NONE;
      clr_addr <= '0;
      energy <= E_RESET;
      magnet <= M_RESET;
    end else begin
      rd_kind <= rd_kind_next;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(LAT_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            state <= site_ok ? ST_QUOT : ST_OUT;
          end
        end
        ST_QUOT: begin
          state <= ST_DIGIT;
        end
        ST_DIGIT: begin
          state <= ST_UP;
        end
        ST_UP: begin
          state <= ST_DOWN;
        end
        ST_DOWN: begin
          state <= (dim == DIM_W'(DIMS - 1)) ? ST_EVAL : ST_QUOT;
        end
        ST_EVAL: begin
          energy <= energy_next;
          magnet <= magnet_next;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (item_out.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (rd_kind == RD_SELF) begin
      spin <= ram_rdata;
    end
    if (rd_kind == RD_NBR) begin
      ups <= ups + UPS_W'(ram_rdata);
    end
    if (state == ST_IDLE && in_accept) begin
      mode <= item_in.mode;
      site <= ADDR_W'(item_in.site);
      cur <= ADDR_W'(item_in.site);
      uniform <= item_in.uniform;
      spin_value <= item_in.spin_value;
      ups <= '0;
      dim <= '0;
      res_flipped <= 1'b0;
      res_spin_now <= 1'b0;
      res_delta <= '0;
      res_energy <= energy;
      res_magnet <= magnet;
    end
    if (state == ST_QUOT) begin
      prod <= PROD_W'(cur) * RECIP;
    end
    if (state == ST_DIGIT) begin
      coord <= SIDE_W'(digit_diff);
      cur <= quot;
    end
    if (state == ST_DOWN) begin
      dim <= dim + DIM_W'(1);
    end
    if (state == ST_EVAL) begin
      res_flipped <= flip;
      res_spin_now <= spin ^ flip;
      res_delta <= de;
      res_energy <= energy_next;
      res_magnet <= magnet_next;
    end
  end

  assign item_out.valid = (state == ST_OUT);
  assign item_out.flipped = res_flipped;
  assign item_out.spin_now = res_spin_now;
  assign item_out.energy_delta = signed'(res_delta);
  assign item_out.energy_now = signed'(res_energy);
  assign item_out.magnetization = signed'(res_magnet);

  ismet_ram #(
    .WIDTH (1),
    .DEPTH (LAT_DEPTH)
  ) u_lattice (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> src/ismet_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ismet_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
